@@ rtl/core/dqmp_pkg.sv @@
// Shared types and constants for the double-ended queue with max purge.
package dqmp_pkg;

	localparam int MODE_W  = 3;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 7;
	localparam int STAT_W  = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_DROP_FRONT = 3'd2,
		MODE_DROP_BACK  = 3'd3,
		MODE_CLEAR      = 3'd4,
		MODE_PURGE_MAX  = 3'd5
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMPACT
	} state_t;

	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

@@ rtl/core/dqmp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dqmp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/deque_with_max_purge_top.sv @@
// Top level of the bounded double-ended queue of signed values with max purge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: mode, value, count.
//   Output channel (out_valid/out_ready) returns one result item per input
//   item: status, occupancy, removed, max_value.
//   Push front/back, drop front/back and clear finish at the accepting edge;
//   the result is valid in the next cycle, so one such item per cycle flows
//   as long as the receiver takes results.
//   A max purge over n held entries runs in two passes after acceptance:
//   the first reads every entry through the single RAM read port to find
//   the maximum, the second reads them again and writes the survivors back
//   in order through the write port. The scan uses a signed greater-than and
//   the compaction a not-equal compare. in_ready is low meanwhile.
//   Reset (arst_n low) empties the queue and returns the head to slot 0;
//   the entry RAM itself is not cleared and needs no clearing pass.
//   When the receiver stalls, the result holds in the output register and
//   in_ready stays low until that result is taken (or is taken in the same
//   cycle a new item is accepted).
module deque_with_max_purge_top #(
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dqmp_pkg::MODE_W-1:0]       mode,
	input  logic signed [dqmp_pkg::VAL_W-1:0] value,
	input  logic [dqmp_pkg::CNT_W-1:0]        count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dqmp_pkg::STAT_W-1:0]       status,
	output logic [dqmp_pkg::CNT_W-1:0]        occupancy,
	output logic [dqmp_pkg::CNT_W-1:0]        removed,
	output logic signed [dqmp_pkg::VAL_W-1:0] max_value
);

	import dqmp_pkg::*;

	// Index width, count width (holds DEPTH itself), sum width, and a width that
	// also covers the 7-bit result and count fields.
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int OW = (CW > CNT_W) ? CW : CNT_W;

	// Ring slot of an offset from the head; the sum stays below 2*DEPTH.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
			input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = {{(SW-AW){1'b0}}, h} + {1'b0, off};
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// Control state
	state_t        state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] rd_q, rd_d;       // offset of the next read in a purge pass
	logic [CW-1:0] k_q, k_d;         // survivors written so far
	logic          rv_s1;            // RAM read data is valid this cycle
	logic          iss;
	logic signed [VAL_W-1:0] max_q, max_d;

	// Result register
	logic                    out_valid_q;
	status_t                 status_q;
	logic [CNT_W-1:0]        occupancy_q;
	logic [CNT_W-1:0]        removed_q;
	logic signed [VAL_W-1:0] max_value_q;

	logic                    ld_out;
	status_t                 st_o;
	logic [CW-1:0]           rem_o;
	logic signed [VAL_W-1:0] max_o;
	logic [OW-1:0]           occ_w;
	logic [OW-1:0]           rem_w;

	// RAM port signals
	logic             we;
	logic [AW-1:0]    waddr;
	logic [VAL_W-1:0] wdata;
	logic [AW-1:0]    raddr;
	logic [VAL_W-1:0] rdata;

	logic          in_acc;
	logic          is_full;
	logic          is_empty;
	logic [OW-1:0] cnt_ext;
	logic [OW-1:0] fill_ext;
	logic [CW-1:0] drop_n;

	// Compares of the current RAM word against the running maximum
	logic cmp_gt;
	logic cmp_ne;

	assign cmp_gt = $signed(rdata) > max_q;
	assign cmp_ne = $signed(rdata) != max_q;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign is_full  = (fill_q == CW'(DEPTH));
	assign is_empty = (fill_q == '0);

	// Saturate a drop at the current fill
	assign cnt_ext  = OW'(count);
	assign fill_ext = OW'(fill_q);
	assign drop_n   = (cnt_ext < fill_ext) ? cnt_ext[CW-1:0] : fill_q;

	dqmp_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Next state, datapath control and RAM accesses
	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		fill_d  = fill_q;
		rd_d    = rd_q;
		k_d     = k_q;
		max_d   = max_q;
		iss     = 1'b0;
		ld_out  = 1'b0;
		st_o    = ST_DONE;
		rem_o   = '0;
		max_o   = '0;
		we      = 1'b0;
		waddr   = slot_of(head_q, k_q);
		wdata   = value;
		raddr   = slot_of(head_q, rd_q);

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					ld_out = 1'b1;
					unique case (mode) inside
						MODE_PUSH_FRONT: begin
							if (is_full) begin
								st_o = ST_FULL;
							end else begin
								head_d = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
								we     = 1'b1;
								waddr  = head_d;
								fill_d = fill_q + 1'b1;
							end
						end
						MODE_PUSH_BACK: begin
							if (is_full) begin
								st_o = ST_FULL;
							end else begin
								we     = 1'b1;
								waddr  = slot_of(head_q, fill_q);
								fill_d = fill_q + 1'b1;
							end
						end
						MODE_DROP_FRONT, MODE_DROP_BACK: begin
							if (is_empty) begin
								st_o = ST_EMPTY;
							end else begin
								if (mode == MODE_DROP_FRONT) begin
									head_d = slot_of(head_q, drop_n);
								end
								fill_d = fill_q - drop_n;
								rem_o  = drop_n;
							end
						end
						MODE_CLEAR: begin
							if (is_empty) begin
								st_o = ST_EMPTY;
							end else begin
								rem_o  = fill_q;
								fill_d = '0;
								head_d = '0;
							end
						end
						MODE_PURGE_MAX: begin
							if (is_empty) begin
								st_o = ST_EMPTY;
							end else begin
								ld_out  = 1'b0;
								state_d = S_SCAN;
								rd_d    = '0;
								max_d   = VAL_MIN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (rd_q != fill_q) begin
					iss  = 1'b1;
					rd_d = rd_q + 1'b1;
				end
				if (rv_s1 && cmp_gt) begin
					max_d = $signed(rdata);
				end
				if (rd_q == fill_q) begin
					state_d = S_COMPACT;
					rd_d    = '0;
					k_d     = '0;
				end
			end
			S_COMPACT: begin
				if (rd_q != fill_q) begin
					iss  = 1'b1;
					rd_d = rd_q + 1'b1;
				end
				if (rv_s1 && cmp_ne) begin
					we    = 1'b1;
					waddr = slot_of(head_q, k_q);
					wdata = rdata;
					k_d   = k_q + 1'b1;
				end
				if (rd_q == fill_q) begin
					state_d = S_IDLE;
					ld_out  = 1'b1;
					fill_d  = k_d;
					rem_o   = fill_q - k_d;
					max_o   = max_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign occ_w = OW'(fill_d);
	assign rem_w = OW'(rem_o);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			rd_q        <= '0;
			k_q         <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q <= head_d;
			fill_q <= fill_d;
			rd_q   <= rd_d;
			k_q    <= k_d;
			rv_s1  <= iss;
			// Hold a result until taken; a new load replaces one taken now
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: running maximum and result fields
	always_ff @(posedge clk) begin
		max_q <= max_d;
		if (ld_out) begin
			status_q    <= st_o;
			occupancy_q <= occ_w[CNT_W-1:0];
			removed_q   <= rem_w[CNT_W-1:0];
			max_value_q <= max_o;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;
	assign removed   = removed_q;
	assign max_value = max_value_q;

	// Fill never exceeds the ring size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count beyond DEPTH");

	// No result is pending while a purge runs
	a_purge_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_valid_q)
		else $error("result pending during purge");

	// Compaction never writes ahead of what it has read
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPACT) |-> (k_q <= rd_q))
		else $error("compaction write pointer ahead of read pointer");

	// An accepted push into a non-full queue grows it by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !is_full &&
			(mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK))
		|=> (fill_q == $past(fill_q) + 1'b1))
		else $error("push did not grow fill count");

endmodule
